// ===== rtl/dynamic_priority_round_scheduler_core_assert.svh =====
// Assertion macros shared by the scheduler RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef DYNAMIC_PRIORITY_ROUND_SCHEDULER_CORE_ASSERT_SVH
`define DYNAMIC_PRIORITY_ROUND_SCHEDULER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define DPRS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dprs assertion failed");
`define DPRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dprs assertion failed");
`else
`define DPRS_ASSERT_SAME(label, ante, cons)
`define DPRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/dprs_pkg.sv =====
// Shared types and constants for the dynamic priority round scheduler.
// No dependencies.
package dprs_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int BURST_W         = 10;
    localparam int PRIO_W          = 16;
    localparam int OUT_IDX_W       = 4;
    localparam int ENTRY_W         = BURST_W + PRIO_W;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_ROUND  = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

endpackage

// ===== rtl/dprs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dprs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dynamic_priority_round_scheduler_core.sv =====
// Dynamic priority round scheduler. An append or a clear is taken without a stall.
// A round keeps the input stalled until it completes. When some entry is ready,
// the round walks the table twice, as the entry RAM has one read port: once to
// find the top priority among ready entries and count them, once to age those
// entries, write them back and emit one beat each. Each result beat that finds the
// output stalled holds the second walk for as long as the stall lasts.
// When no entry is ready, or the table is empty, the round emits one all-done beat.
// Depends on dprs_pkg, dprs_ram and the assertion macro header.
`include "dynamic_priority_round_scheduler_core_assert.svh"

module dynamic_priority_round_scheduler_core #(
    parameter int MAX_ENTRIES = dprs_pkg::DEF_MAX_ENTRIES
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_func,
    input  logic [dprs_pkg::BURST_W-1:0]           i_burst_in,
    input  logic signed [dprs_pkg::PRIO_W-1:0]     i_priority_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [dprs_pkg::OUT_IDX_W-1:0]         o_entry_index,
    output logic [dprs_pkg::BURST_W-1:0]           o_burst_left,
    output logic signed [dprs_pkg::PRIO_W-1:0]     o_priority_now,
    output logic                                   o_finished,
    output logic                                   o_all_done,
    output logic                                   o_last
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int BW    = dprs_pkg::BURST_W;
    localparam int PW    = dprs_pkg::PRIO_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_EMPTY  = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [MAX_ENTRIES-1:0] r_ready, n_ready;
    logic [CNT_W-1:0]       r_rd_idx, n_rd_idx;
    logic                   r_dv, n_dv;
    logic [IDX_W-1:0]       r_dv_idx, n_dv_idx;
    logic                   r_any, n_any;
    logic signed [PW-1:0]   r_high, n_high;
    logic [CNT_W-1:0]       r_remain, n_remain;

    logic                   r_o_valid;
    logic [IDX_W-1:0]       r_o_idx;
    logic [BW-1:0]          r_o_burst;
    logic signed [PW-1:0]   r_o_prio;
    logic                   r_o_fin;
    logic                   r_o_done;
    logic                   r_o_last;

    logic                          w_in_beat;
    logic [dprs_pkg::ENTRY_W-1:0]  w_rdata;
    logic [BW-1:0]                 w_rd_burst;
    logic signed [PW-1:0]          w_rd_prio;
    logic                          w_rd_ready;
    logic                          w_gt;
    logic                          w_eq;
    logic                          w_out_free;
    logic                          w_hit;
    logic                          w_consume;
    logic                          w_issue;
    logic                          w_pass_end;
    logic [BW-1:0]                 w_new_burst;
    logic signed [PW-1:0]          w_new_prio;
    logic                          w_new_fin;
    logic                          w_emit_entry;
    logic                          w_emit_empty;
    logic                          w_append;
    logic                          w_we;
    logic [IDX_W-1:0]              w_waddr;
    logic [dprs_pkg::ENTRY_W-1:0]  w_wdata;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_beat  = i_in_valid && !o_in_stall;

    // one comparator serves both walks
    assign w_rd_burst = w_rdata[BW-1:0];
    assign w_rd_prio  = w_rdata[dprs_pkg::ENTRY_W-1:BW];
    assign w_rd_ready = r_ready[r_dv_idx];
    assign w_gt       = w_rd_prio > r_high;
    assign w_eq       = w_rd_prio == r_high;

    assign w_out_free = !r_o_valid || !i_out_stall;
    assign w_hit      = (r_state == ST_UPDATE) && r_dv && w_rd_ready && w_eq;
    assign w_consume  = (r_state == ST_SCAN)
                     || ((r_state == ST_UPDATE) && (!w_hit || w_out_free));
    assign w_issue    = w_consume && (r_rd_idx < r_count);
    assign w_pass_end = !r_dv && (r_rd_idx == r_count);

    assign w_new_burst = (w_rd_burst == '0) ? '0 : BW'(w_rd_burst - BW'(1));
    assign w_new_prio  = (w_rd_prio == dprs_pkg::PRIO_MIN) ? w_rd_prio
                                                           : PW'(w_rd_prio - PW'(1));
    assign w_new_fin   = (w_new_burst == '0);

    assign w_emit_entry = w_hit && w_out_free;
    assign w_emit_empty = (r_state == ST_EMPTY) && w_out_free;

    assign w_append = w_in_beat && (i_func == dprs_pkg::FUNC_APPEND)
                   && (r_count < CNT_W'(MAX_ENTRIES));

    assign w_we    = w_append || w_emit_entry;
    assign w_waddr = w_append ? r_count[IDX_W-1:0] : r_dv_idx;
    assign w_wdata = w_append ? {i_priority_in, i_burst_in} : {w_new_prio, w_new_burst};

    dprs_ram #(
        .WIDTH (dprs_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ready  = r_ready;
        n_rd_idx = r_rd_idx;
        n_dv     = r_dv;
        n_dv_idx = r_dv_idx;
        n_any    = r_any;
        n_high   = r_high;
        n_remain = r_remain;

        if (w_consume) begin
            n_dv = w_issue;
            if (w_issue) begin
                n_dv_idx = r_rd_idx[IDX_W-1:0];
                n_rd_idx = r_rd_idx + CNT_W'(1);
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_beat) begin
                    unique case (i_func)
                        dprs_pkg::FUNC_APPEND: begin
                            if (w_append) begin
                                n_ready[r_count[IDX_W-1:0]] = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        dprs_pkg::FUNC_ROUND: begin
                            n_state  = ST_SCAN;
                            n_rd_idx = '0;
                            n_dv     = 1'b0;
                            n_any    = 1'b0;
                            n_remain = '0;
                        end
                        dprs_pkg::FUNC_CLEAR: begin
                            n_ready = '0;
                            n_count = '0;
                        end
                        dprs_pkg::FUNC_NOP: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // running maximum and the number of ready entries holding it
                if (r_dv && w_rd_ready) begin
                    if (!r_any || w_gt) begin
                        n_high   = w_rd_prio;
                        n_any    = 1'b1;
                        n_remain = CNT_W'(1);
                    end else if (w_eq) begin
                        n_remain = r_remain + CNT_W'(1);
                    end
                end
                if (w_pass_end) begin
                    n_state  = r_any ? ST_UPDATE : ST_EMPTY;
                    n_rd_idx = '0;
                    n_dv     = 1'b0;
                end
            end
            ST_UPDATE: begin
                if (w_emit_entry) begin
                    n_remain = r_remain - CNT_W'(1);
                    if (w_new_fin) begin
                        n_ready[r_dv_idx] = 1'b0;
                    end
                end
                if (w_pass_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_ready   <= '0;
            r_rd_idx  <= '0;
            r_dv      <= 1'b0;
            r_any     <= 1'b0;
            r_remain  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ready  <= n_ready;
            r_rd_idx <= n_rd_idx;
            r_dv     <= n_dv;
            r_any    <= n_any;
            r_remain <= n_remain;
            if (w_emit_entry || w_emit_empty) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_idx <= n_dv_idx;
        r_high   <= n_high;
        if (w_emit_entry) begin
            r_o_idx   <= r_dv_idx;
            r_o_burst <= w_new_burst;
            r_o_prio  <= w_new_prio;
            r_o_fin   <= w_new_fin;
            r_o_done  <= 1'b0;
            r_o_last  <= (r_remain == CNT_W'(1));
        end else if (w_emit_empty) begin
            r_o_idx   <= '0;
            r_o_burst <= '0;
            r_o_prio  <= '0;
            r_o_fin   <= 1'b0;
            r_o_done  <= 1'b1;
            r_o_last  <= 1'b1;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_entry_index  = dprs_pkg::OUT_IDX_W'(r_o_idx);
    assign o_burst_left   = r_o_burst;
    assign o_priority_now = r_o_prio;
    assign o_finished     = r_o_fin;
    assign o_all_done     = r_o_done;
    assign o_last         = r_o_last;

    // an all-done beat is always the only beat of its round
    `DPRS_ASSERT_SAME(a_done_is_last, r_o_valid && r_o_done, r_o_last && !r_o_fin)
    `DPRS_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_ENTRIES))
    // the scan count must cover every entry the update walk hits
    `DPRS_ASSERT_SAME(a_hit_counted, w_hit, r_remain != '0)
    `DPRS_ASSERT_NEXT(a_round_starts,
        w_in_beat && (i_func == dprs_pkg::FUNC_ROUND), r_state == ST_SCAN)

endmodule
